### design/rate_monotonic_ready_queue_core_assert.svh
// Assertion macros shared by the ready queue RTL.
`ifndef RATE_MONOTONIC_READY_QUEUE_CORE_ASSERT_SVH
`define RATE_MONOTONIC_READY_QUEUE_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define RMRQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define RMRQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

### design/rmrq_pkg.sv
// Types, codes and constants of the rate-monotonic ready queue.
`timescale 1ns / 1ps
`default_nettype none

package rmrq_pkg;

    localparam int PERIOD_W  = 64;
    localparam int TASK_W    = 8;
    localparam int OPC_W     = 2;
    localparam int STAT_W    = 2;
    localparam int PRIO_W    = 7;
    localparam int COUNT_W   = 5;
    localparam int LOG_W     = 6;
    localparam int LOG_SIZE  = 64;

    localparam int MIN_PRIO  = 10;
    localparam int PRIO_SPAN = 89;
    localparam int LOG2_TOP  = 63;

    typedef enum logic [OPC_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_REQUEUE = 2'd2
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DUPLICATE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_CMP    = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_INSERT = 2'd3
    } t_cell_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_MOD,
        S_CMP,
        S_INS2,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [OPC_W-1:0]    opcode;
        logic [TASK_W-1:0]   task_id;
        logic [PERIOD_W-1:0] period;
    } t_in_item;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [PRIO_W-1:0]   priority_res;
        logic                head_valid;
        logic [TASK_W-1:0]   head_task;
        logic [PERIOD_W-1:0] head_period;
        logic [COUNT_W-1:0]  queued_count;
    } t_out_item;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        t_cell_cmd           cmd;
        logic [PERIOD_W-1:0] key;
    } t_cell_ctl;

    typedef logic [PRIO_W-1:0] t_prio_lut [LOG_SIZE];

    // Priority for each floor(log2(period)); the quotient is stepped up
    // incrementally so no division is needed.
    function automatic t_prio_lut build_prio_lut();
        t_prio_lut lut;
        int        q;
        int        num;
        q = 0;
        for (int l = 0; l < LOG_SIZE; l++) begin
            num = PRIO_SPAN * l;
            while (LOG2_TOP * (q + 1) <= num) begin
                q = q + 1;
            end
            lut[l] = PRIO_W'(MIN_PRIO + q);
        end
        return lut;
    endfunction

    localparam t_prio_lut PRIO_LUT = build_prio_lut();

endpackage

`default_nettype wire

### design/rmrq_log2.sv
// Two-stage floor(log2) unit for a 64-bit period.
`timescale 1ns / 1ps
`default_nettype none

module rmrq_log2 (
    input  wire logic                         i_clk,
    input  wire logic [rmrq_pkg::PERIOD_W-1:0] i_value,
    output logic      [rmrq_pkg::LOG_W-1:0]    o_log
);
    import rmrq_pkg::*;

    localparam int CHUNK_W = 8;
    localparam int CHUNKS  = PERIOD_W / CHUNK_W;
    localparam int POS_W   = $clog2(CHUNK_W);
    localparam int SEL_W   = $clog2(CHUNKS);

    logic [CHUNKS-1:0] r_nz;
    logic [CHUNKS-1:0] n_nz;
    logic [POS_W-1:0]  r_pos [CHUNKS];
    logic [POS_W-1:0]  n_pos [CHUNKS];
    logic [LOG_W-1:0]  r_log;
    logic [LOG_W-1:0]  n_log;

    // First stage: highest set bit within each byte.
    always_comb begin
        for (int c = 0; c < CHUNKS; c++) begin
            n_nz[c]  = |i_value[c*CHUNK_W +: CHUNK_W];
            n_pos[c] = '0;
            for (int j = 0; j < CHUNK_W; j++) begin
                if (i_value[c*CHUNK_W + j]) begin
                    n_pos[c] = POS_W'(j);
                end
            end
        end
    end

    // Second stage: the highest nonzero byte supplies the upper bits.
    always_comb begin
        n_log = '0;
        for (int c = 0; c < CHUNKS; c++) begin
            if (r_nz[c]) begin
                n_log = {SEL_W'(c), r_pos[c]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nz  <= n_nz;
        r_pos <= n_pos;
        r_log <= n_log;
    end

    assign o_log = r_log;

endmodule

`default_nettype wire

### design/rmrq_cell.sv
// One slot of the sorted queue row; shifts toward either neighbor.
`timescale 1ns / 1ps
`default_nettype none

module rmrq_cell #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 8,
    parameter int IDX     = 0
) (
    input  wire logic                              i_clk,
    input  wire rmrq_pkg::t_cell_ctl               i_ctl,
    input  wire logic [ID_BITS-1:0]                i_id,
    input  wire logic [$clog2(DEPTH)-1:0]          i_rm_idx,
    input  wire logic [$clog2(DEPTH+1)-1:0]        i_count,
    input  wire logic                              i_left_le,
    input  wire logic [ID_BITS-1:0]                i_left_task,
    input  wire logic [rmrq_pkg::PERIOD_W-1:0]     i_left_period,
    input  wire logic [ID_BITS-1:0]                i_right_task,
    input  wire logic [rmrq_pkg::PERIOD_W-1:0]     i_right_period,
    output logic      [ID_BITS-1:0]                o_task,
    output logic      [rmrq_pkg::PERIOD_W-1:0]     o_period,
    output logic                                   o_le,
    output logic                                   o_match
);
    import rmrq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(IDX);
    localparam logic [CNT_W-1:0] MY_COUNT = CNT_W'(IDX);

    logic [ID_BITS-1:0]  r_task;
    logic [ID_BITS-1:0]  n_task;
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] n_period;
    logic                r_le;
    logic                n_le;
    logic                w_in_use;

    assign w_in_use = MY_COUNT < i_count;

    always_comb begin
        n_task   = r_task;
        n_period = r_period;
        n_le     = r_le;
        unique case (i_ctl.cmd)
            CMD_HOLD: begin
            end
            CMD_CMP: begin
                n_le = w_in_use && (r_period <= i_ctl.key);
            end
            CMD_REMOVE: begin
                if (MY_IDX >= i_rm_idx) begin
                    n_task   = i_right_task;
                    n_period = i_right_period;
                end
            end
            CMD_INSERT: begin
                // Keep if at or below the key; the first cell past it takes
                // the new entry and everything behind moves one place right.
                if (!r_le) begin
                    if (i_left_le) begin
                        n_task   = i_id;
                        n_period = i_ctl.key;
                    end else begin
                        n_task   = i_left_task;
                        n_period = i_left_period;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_task   <= n_task;
        r_period <= n_period;
        r_le     <= n_le;
    end

    assign o_task   = r_task;
    assign o_period = r_period;
    assign o_le     = r_le;
    assign o_match  = w_in_use && (r_task == i_id);

endmodule

`default_nettype wire

### design/rate_monotonic_ready_queue_core.sv
// Top level of the rate-monotonic ready queue.
`timescale 1ns / 1ps
`default_nettype none

// Rate-monotonic ready queue. Up to DEPTH tasks (id and 64-bit period) sit
// in a row of cells kept in ascending period order, equal periods in arrival
// order, so the head is always cell zero. Each input item is one command:
// enqueue, dequeue by id, or requeue behind equal-period peers. Every item
// produces exactly one result item carrying a status, the rate-monotonic
// priority of the enqueued period (10 otherwise), the head task with its
// period and the count of queued tasks. An item is processed by a small
// sequencer that drives the whole cell row one command per cycle: a find
// step in which every cell compares its id and period against the item,
// then one shift step (insert or remove). A requeue, which removes,
// compares again and reinserts, follows its removal with a second compare
// step and an insert step. The priority comes from a two-stage log2 unit
// and a constant table, whose latency is hidden behind the find and shift
// steps. The result sits in an output register, so the next item is taken
// as soon as the result is loaded, even if the consumer has not yet picked
// it up. There is no clearing pass after reset; the count alone marks
// which cells hold tasks.
module rate_monotonic_ready_queue_core #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire rmrq_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output rmrq_pkg::t_out_item      o_out
);
    import rmrq_pkg::*;

    `include "rate_monotonic_ready_queue_core_assert.svh"

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    // Sequencer and item registers.
    t_state              r_state;
    t_state              n_state;
    logic [OPC_W-1:0]    r_op;
    logic [ID_BITS-1:0]  r_id;
    logic [PERIOD_W-1:0] r_key;
    logic [PERIOD_W-1:0] n_key;
    logic [PERIOD_W-1:0] r_pin;
    t_status             r_status;
    t_status             n_status;
    logic [IDX_W-1:0]    r_k;
    logic [CNT_W-1:0]    r_count;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                w_in_acc;
    logic                w_load_out;
    t_cell_ctl           w_ctl;
    logic                w_found;
    logic [IDX_W-1:0]    w_k;
    logic [PERIOD_W-1:0] w_match_period;
    logic [LOG_W-1:0]    w_log;
    t_out_item           w_result;

    // Cell row taps.
    logic [ID_BITS-1:0]  w_task   [DEPTH];
    logic [PERIOD_W-1:0] w_period [DEPTH];
    logic [DEPTH-1:0]    w_le;
    logic [DEPTH-1:0]    w_match;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // The row of cells; each sees its left and right neighbor only.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                w_left_le;
        logic [ID_BITS-1:0]  w_left_task;
        logic [PERIOD_W-1:0] w_left_period;
        logic [ID_BITS-1:0]  w_right_task;
        logic [PERIOD_W-1:0] w_right_period;

        if (g == 0) begin : g_first
            assign w_left_le     = 1'b1;
            assign w_left_task   = '0;
            assign w_left_period = '0;
        end else begin : g_inner_left
            assign w_left_le     = w_le[g-1];
            assign w_left_task   = w_task[g-1];
            assign w_left_period = w_period[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_task   = '0;
            assign w_right_period = '0;
        end else begin : g_inner_right
            assign w_right_task   = w_task[g+1];
            assign w_right_period = w_period[g+1];
        end

        rmrq_cell #(
            .DEPTH   (DEPTH),
            .ID_BITS (ID_BITS),
            .IDX     (g)
        ) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_id           (r_id),
            .i_rm_idx       (r_k),
            .i_count        (r_count),
            .i_left_le      (w_left_le),
            .i_left_task    (w_left_task),
            .i_left_period  (w_left_period),
            .i_right_task   (w_right_task),
            .i_right_period (w_right_period),
            .o_task         (w_task[g]),
            .o_period       (w_period[g]),
            .o_le           (w_le[g]),
            .o_match        (w_match[g])
        );
    end

    // Ids are unique, so at most one cell matches and a plain OR of the
    // masked cell values recovers its index and period.
    always_comb begin
        w_found        = |w_match;
        w_k            = '0;
        w_match_period = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_match[i]) begin
                w_k            = w_k | IDX_W'(i);
                w_match_period = w_match_period | w_period[i];
            end
        end
    end

    // The priority follows the period captured at accept and is ready by the
    // time the result is loaded.
    rmrq_log2 u_log2 (
        .i_clk   (i_clk),
        .i_value (r_pin),
        .o_log   (w_log)
    );

    // Sequencer: one command to the whole row per cycle.
    always_comb begin
        n_state    = r_state;
        n_key      = r_key;
        n_status   = r_status;
        w_ctl.cmd  = CMD_HOLD;
        w_ctl.key  = r_key;
        w_load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_FIND;
                    n_key   = i_in.period;
                end
            end
            S_FIND: begin
                w_ctl.cmd = CMD_CMP;
                n_status  = ST_OK;
                if (r_op == OP_ENQUEUE) begin
                    // A duplicate id takes precedence over a full queue.
                    priority if (w_found) begin
                        n_status = ST_DUPLICATE;
                    end else if (r_count == FULL_COUNT) begin
                        n_status = ST_FULL;
                    end
                end else if (r_op == OP_DEQUEUE || r_op == OP_REQUEUE) begin
                    if (!w_found) begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                // A requeue reinserts with the period it already holds.
                if (r_op == OP_REQUEUE && w_found) begin
                    n_key = w_match_period;
                end
                n_state = S_MOD;
            end
            S_MOD: begin
                if (r_op == OP_ENQUEUE && r_status == ST_OK) begin
                    w_ctl.cmd = CMD_INSERT;
                end else if ((r_op == OP_DEQUEUE || r_op == OP_REQUEUE)
                             && r_status == ST_OK) begin
                    w_ctl.cmd = CMD_REMOVE;
                end
                if (r_op == OP_REQUEUE && r_status == ST_OK) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                w_ctl.cmd = CMD_CMP;
                n_state   = S_INS2;
            end
            S_INS2: begin
                w_ctl.cmd = CMD_INSERT;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result assembly from the row head and the sequencer registers.
    always_comb begin
        w_result.status       = r_status;
        w_result.priority_res = (r_op == OP_ENQUEUE) ? PRIO_LUT[w_log] : PRIO_W'(MIN_PRIO);
        w_result.head_valid   = (r_count != '0);
        w_result.head_task    = (r_count != '0) ? TASK_W'(w_task[0]) : '0;
        w_result.head_period  = (r_count != '0) ? w_period[0] : '0;
        w_result.queued_count = COUNT_W'(r_count);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.cmd == CMD_INSERT) begin
                r_count <= r_count + 1'b1;
            end else if (w_ctl.cmd == CMD_REMOVE) begin
                r_count <= r_count - 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key    <= n_key;
        r_status <= n_status;
        if (w_in_acc) begin
            r_op  <= i_in.opcode;
            r_id  <= ID_BITS'(i_in.task_id);
            r_pin <= i_in.period;
        end
        if (r_state == S_FIND) begin
            r_k <= w_k;
        end
        if (w_load_out) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The count never exceeds the number of cells.
    `RMRQ_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= FULL_COUNT, "queue count exceeds depth")
    // An insert grows the queue by exactly one task.
    `RMRQ_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, w_ctl.cmd == CMD_INSERT, r_count == $past(r_count) + 1'b1, "insert did not add one task")
    // A removal shrinks the queue by exactly one task.
    `RMRQ_ASSERT_NEXT(a_remove_count, i_clk, i_rst_n, w_ctl.cmd == CMD_REMOVE, r_count == $past(r_count) - 1'b1, "remove did not drop one task")
    // A shown head is valid exactly when the queue is not empty.
    `RMRQ_ASSERT(a_head_valid, i_clk, i_rst_n, !o_out_valid || (o_out.head_valid == (o_out.queued_count != '0)), "head valid disagrees with count")

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the rate-monotonic ready queue core.
`timescale 1ns / 1ps

// The bench pushes scheduler commands (enqueue, dequeue, requeue and the
// unused opcode) through the valid/ready input channel and checks every
// result item against a predictor. The predictor keeps its own sorted copy
// of the ready queue: ascending period, with equal periods in arrival order.
// A short directed list comes first. It covers the empty queue, the
// extremes of period and id, ties and requeue among equal periods, the
// unused opcode, a full queue and a duplicate id while full. Random blocks
// follow. Each block leans toward filling, draining or a balanced mix, so
// the queue swings between empty and full many times.
module tb;
    import rmrq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1450;
    localparam int BLOCK_ITEMS  = 40;
    localparam int IDLE_PCT     = 22;
    localparam int QUIET_START  = 3000;
    localparam int QUIET_STOP   = 6000;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_item = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out;

    // Commands not yet offered to the block, and the results that are owed.
    t_in_item  sched_cmds[$];
    t_out_item head_reports_due[$];

    // Predictor copy of the ready queue.
    logic [TASK_W-1:0]   rq_task[DEPTH];
    logic [PERIOD_W-1:0] rq_period[DEPTH];
    int                  rq_count = 0;

    // Membership seen by the stimulus generator. It is used to aim dequeues,
    // requeues and duplicates at tasks that are actually queued.
    bit                gen_present[256];
    logic [TASK_W-1:0] gen_ids[$];

    int cycle_count = 0;
    int error_count = 0;
    int results_seen = 0;
    int n_enq = 0, n_deq = 0, n_req = 0, n_other = 0;
    int n_full = 0, n_dup = 0, n_missing = 0, max_depth = 0;

    wire quiet_window = (cycle_count >= QUIET_START) && (cycle_count < QUIET_STOP);

    rate_monotonic_ready_queue_core #(
        .DEPTH   (DEPTH),
        .ID_BITS (8)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always #1 i_clk = ~i_clk;

    // Close the gap left by the entry at index k.
    function automatic void rq_remove(int k);
        for (int i = k; i + 1 < rq_count; i++) begin
            rq_task[i]   = rq_task[i + 1];
            rq_period[i] = rq_period[i + 1];
        end
        rq_count--;
    endfunction

    // Insert behind every entry whose period is equal or smaller.
    function automatic void rq_insert(logic [TASK_W-1:0] id, logic [PERIOD_W-1:0] per);
        int pos;
        pos = 0;
        while (pos < rq_count && rq_period[pos] <= per) pos++;
        for (int i = rq_count; i > pos; i--) begin
            rq_task[i]   = rq_task[i - 1];
            rq_period[i] = rq_period[i - 1];
        end
        rq_task[pos]   = id;
        rq_period[pos] = per;
        rq_count++;
    endfunction

    // Apply one command to the predictor queue and return the result it owes.
    function automatic t_out_item rm_queue_apply(t_in_item cmd);
        t_out_item           res;
        int                  slot;
        int                  lg;
        logic [PERIOD_W-1:0] kept;
        res = '0;
        res.status = ST_OK;
        res.priority_res = PRIO_W'(MIN_PRIO);
        slot = -1;
        for (int i = rq_count - 1; i >= 0; i--) begin
            if (rq_task[i] == cmd.task_id) slot = i;
        end
        case (cmd.opcode)
            OP_ENQUEUE: begin
                n_enq++;
                // The priority is reported even when the enqueue is refused.
                if (cmd.period != '0) begin
                    lg = 0;
                    for (int b = 0; b < PERIOD_W; b++) begin
                        if (cmd.period[b]) lg = b;
                    end
                    res.priority_res = PRIO_W'(MIN_PRIO + (PRIO_SPAN * lg) / LOG2_TOP);
                end
                // The duplicate check takes precedence over the full check.
                if (slot >= 0) begin
                    res.status = ST_DUPLICATE;
                    n_dup++;
                end else if (rq_count >= DEPTH) begin
                    res.status = ST_FULL;
                    n_full++;
                end else begin
                    rq_insert(cmd.task_id, cmd.period);
                end
            end
            OP_DEQUEUE: begin
                n_deq++;
                if (slot < 0) begin
                    res.status = ST_NOT_FOUND;
                    n_missing++;
                end else begin
                    rq_remove(slot);
                end
            end
            OP_REQUEUE: begin
                // The stored period is kept; the period field of the item is ignored.
                n_req++;
                if (slot < 0) begin
                    res.status = ST_NOT_FOUND;
                    n_missing++;
                end else begin
                    kept = rq_period[slot];
                    rq_remove(slot);
                    rq_insert(cmd.task_id, kept);
                end
            end
            default: begin
                n_other++;
            end
        endcase
        if (rq_count > 0) begin
            res.head_valid  = 1'b1;
            res.head_task   = rq_task[0];
            res.head_period = rq_period[0];
        end
        res.queued_count = COUNT_W'(rq_count);
        if (rq_count > max_depth) max_depth = rq_count;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR result %0d: %s got %0h expected %0h", results_seen, what, got, want);
        error_count++;
    endtask

    // Append one command and track what the queue will hold after it.
    task automatic queue_cmd(logic [OPC_W-1:0] op, logic [TASK_W-1:0] id,
                             logic [PERIOD_W-1:0] per);
        t_in_item it;
        it.opcode  = op;
        it.task_id = id;
        it.period  = per;
        sched_cmds.push_back(it);
        if (op == OP_ENQUEUE && !gen_present[id] && gen_ids.size() < DEPTH) begin
            gen_present[id] = 1'b1;
            gen_ids.push_back(id);
        end else if (op == OP_DEQUEUE && gen_present[id]) begin
            gen_present[id] = 1'b0;
            for (int i = 0; i < gen_ids.size(); i++) begin
                if (gen_ids[i] == id) begin
                    gen_ids.delete(i);
                    break;
                end
            end
        end
    endtask

    // Periods come from a short list (to force ties), from a random magnitude
    // (so every floor(log2) is reached), or from all 64 bits at random.
    function automatic logic [PERIOD_W-1:0] pick_period();
        logic [PERIOD_W-1:0] common_periods[8];
        int                  r;
        common_periods = '{64'd0, 64'd1, 64'd2, 64'd1000, 64'd1000, 64'd4096,
                           64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF};
        r = $urandom_range(99);
        if (r < 40) return common_periods[$urandom_range(7)];
        if (r < 80) return {$urandom, $urandom} >> $urandom_range(63);
        return {$urandom, $urandom};
    endfunction

    // Ids mostly come from a small pool at both ends of the range, so that
    // collisions happen often.
    function automatic logic [TASK_W-1:0] pick_id(bit want_present);
        int r;
        if (want_present && gen_ids.size() > 0) begin
            return gen_ids[$urandom_range(gen_ids.size() - 1)];
        end
        r = $urandom_range(99);
        if (r < 40) return TASK_W'($urandom_range(11));
        if (r < 70) return TASK_W'($urandom_range(255, 244));
        return TASK_W'($urandom_range(255));
    endfunction

    // Driver: offer the next command once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                head_reports_due.push_back(rm_queue_apply(in_item));
            end
            if (!in_valid || o_in_ready) begin
                if (sched_cmds.size() > 0 && (quiet_window || $urandom_range(99) >= IDLE_PCT)) begin
                    in_item  <= sched_cmds.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result item with the oldest one owed.
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            out_ready <= quiet_window || ($urandom_range(99) >= IDLE_PCT);
            if (o_out_valid && out_ready) begin
                results_seen++;
                if (head_reports_due.size() == 0) begin
                    report_mismatch("result with nothing owed, status", o_out.status, 0);
                end else begin
                    want = head_reports_due.pop_front();
                    if (o_out.status !== want.status)
                        report_mismatch("status", o_out.status, want.status);
                    if (o_out.priority_res !== want.priority_res)
                        report_mismatch("priority_res", o_out.priority_res, want.priority_res);
                    if (o_out.head_valid !== want.head_valid)
                        report_mismatch("head_valid", o_out.head_valid, want.head_valid);
                    if (o_out.head_task !== want.head_task)
                        report_mismatch("head_task", o_out.head_task, want.head_task);
                    if (o_out.head_period !== want.head_period)
                        report_mismatch("head_period", o_out.head_period, want.head_period);
                    if (o_out.queued_count !== want.queued_count)
                        report_mismatch("queued_count", o_out.queued_count, want.queued_count);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results owed", cycle_count,
                     head_reports_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int          mode;
        int          r;
        int          enq_pct;
        int          deq_pct;
        logic [OPC_W-1:0] op;

        // Directed part. It starts on an empty queue, where dequeue and
        // requeue both miss.
        queue_cmd(OP_DEQUEUE, 8'd5, 64'd0);
        queue_cmd(OP_REQUEUE, 8'd5, 64'd0);
        // Smallest and largest period and id, and a duplicate id.
        queue_cmd(OP_ENQUEUE, 8'd0, 64'd0);
        queue_cmd(OP_ENQUEUE, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_cmd(OP_ENQUEUE, 8'd0, 64'd1);
        queue_cmd(OP_ENQUEUE, 8'd18, 64'h8000_0000_0000_0000);
        // Three tasks of equal period; a requeue moves the first one behind the others.
        queue_cmd(OP_ENQUEUE, 8'd40, 64'd1000);
        queue_cmd(OP_ENQUEUE, 8'd41, 64'd1000);
        queue_cmd(OP_ENQUEUE, 8'd42, 64'd1000);
        queue_cmd(OP_REQUEUE, 8'd40, 64'd7);
        queue_cmd(OP_UNUSED, 8'd41, 64'd5);
        // Removing the head exposes the next entry.
        queue_cmd(OP_DEQUEUE, 8'd0, 64'd0);
        // Fill to capacity, then overflow, then a duplicate while full.
        queue_cmd(OP_ENQUEUE, 8'hAA, 64'h5555_5555_5555_5555);
        queue_cmd(OP_ENQUEUE, 8'h55, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_cmd(OP_ENQUEUE, 8'd1, 64'd1);
        queue_cmd(OP_ENQUEUE, 8'd2, 64'd2);
        queue_cmd(OP_ENQUEUE, 8'd3, 64'd3);
        for (int i = 0; i < 6; i++) begin
            queue_cmd(OP_ENQUEUE, TASK_W'(100 + i), 64'd1 << (4 + 9 * i));
        end
        queue_cmd(OP_ENQUEUE, 8'd110, 64'd0);
        queue_cmd(OP_ENQUEUE, 8'd255, 64'd12);

        // Random part, in blocks that lean toward fill, drain or a mix.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BLOCK_ITEMS == 0) begin
                mode = $urandom_range(2);
                enq_pct = (mode == 0) ? 65 : (mode == 1) ? 25 : 42;
                deq_pct = (mode == 0) ? 20 : (mode == 1) ? 55 : 35;
            end
            r = $urandom_range(99);
            if (r < enq_pct) begin
                op = OP_ENQUEUE;
            end else if (r < enq_pct + deq_pct) begin
                op = OP_DEQUEUE;
            end else if (r < 98) begin
                op = OP_REQUEUE;
            end else begin
                op = OP_UNUSED;
            end
            if (op == OP_ENQUEUE) begin
                // Some enqueues deliberately repeat an id that is already queued.
                queue_cmd(op, pick_id($urandom_range(99) < 15), pick_period());
            end else begin
                queue_cmd(op, pick_id($urandom_range(99) < 80), pick_period());
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (sched_cmds.size() != 0 || in_valid) @(posedge i_clk);
        while (head_reports_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d results: %0d enqueues, %0d dequeues, %0d requeues, %0d unused",
                 results_seen, n_enq, n_deq, n_req, n_other);
        $display("Refusals: %0d full, %0d duplicate, %0d missing id; deepest queue %0d",
                 n_full, n_dup, n_missing, max_depth);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/rmrq_pkg.sv
design/rmrq_log2.sv
design/rmrq_cell.sv
design/rate_monotonic_ready_queue_core.sv
bench/tb.sv
